// ===== rtl/shared_pool_multi_stack_macros.svh =====
// Assertion macros for the shared-pool multi-stack block.
// Used by the top level; no other dependencies.
`ifndef SHARED_POOL_MULTI_STACK_MACROS_SVH
`define SHARED_POOL_MULTI_STACK_MACROS_SVH

`ifndef SYNTHESIS

// Whenever ante holds at a clock edge, cons holds at the next edge.
`define SPMS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("spms: next-cycle check failed");

// Whenever ante holds at a clock edge, cons holds at the same edge.
`define SPMS_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("spms: same-cycle check failed");

`else

`define SPMS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`define SPMS_ASSERT_SAME(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/spms_pkg.sv =====
// Shared definitions for the shared-pool multi-stack block.
// Holds command and status codes, default sizes and the control types.
`default_nettype none

package spms_pkg;

    localparam int ENTRIES_PER_STACK_DEF = 1024;
    localparam int NUM_STACKS_DEF        = 3;

    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int DATA_W   = 32;

    localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TOP  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    // Requests from the sequencer to the free list, valid in the execute cycle.
    typedef struct packed {
        logic take;
        logic give;
    } fl_ctrl_t;

    // Free-list condition seen by the sequencer.
    typedef struct packed {
        logic none_free;
        logic room;
    } fl_stat_t;

endpackage

`default_nettype wire

// ===== rtl/shared_pool_multi_stack.sv =====
// Top level of the shared-pool multi-stack: head pointers, node RAM, sequencer.
// Depends on spms_pkg, spms_ram, spms_free_list and the assertion macro header.
//
// Usage:
//   Several stacks share one pool of nodes. A command beat is taken at a rising
//   edge where start is high and busy is low; it carries cmd (push, pop, top),
//   stack_id and value. Every command yields one result beat: done is high for
//   exactly one cycle with status and data, and the receiver cannot hold it off.
//   The command edge loads the command registers and enters the execute
//   state, and done is registered from the execute state. The command
//   cycle reads the node RAM at the addressed head and the free-list RAM at its
//   top; the execute cycle uses that registered read data to update the head
//   pointer, the node RAM and the free list. busy is high during the execute
//   cycle, so a new command is taken only after the current one has executed.
//   A result sits in its output register while the next command is accepted.
//   Reset clears all stacks to empty and fills the free list with every node;
//   it needs no clearing pass and the block takes a command right after reset.
//   A push into a full pool returns status full, pop or top on an empty stack
//   returns status empty; neither changes any state.
`default_nettype none
`include "shared_pool_multi_stack_macros.svh"

module shared_pool_multi_stack #(
    parameter int ENTRIES_PER_STACK = spms_pkg::ENTRIES_PER_STACK_DEF,
    parameter int NUM_STACKS        = spms_pkg::NUM_STACKS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [spms_pkg::CMD_W-1:0]          cmd,
    input  wire logic [1:0]                          stack_id,
    input  wire logic signed [spms_pkg::DATA_W-1:0]  value,
    output logic                                     done,
    output logic      [spms_pkg::STATUS_W-1:0]       status,
    output logic signed [spms_pkg::DATA_W-1:0]       data
);

    localparam int POOL   = NUM_STACKS * ENTRIES_PER_STACK;
    localparam int PTR_W  = $clog2(POOL + 1);
    localparam int ADDR_W = $clog2(POOL);
    localparam int SID_W  = $clog2(NUM_STACKS);
    localparam int SIDX_W = SID_W + 2;
    localparam int NODE_W = spms_pkg::DATA_W + PTR_W;
    localparam logic [PTR_W-1:0] NODE_NULL = PTR_W'(POOL);

    spms_pkg::state_t state_reg, state_next;

    logic [spms_pkg::CMD_W-1:0]    cmd_reg;
    logic [SID_W-1:0]              sid_reg;
    logic                          sid_ok_reg;
    logic [spms_pkg::DATA_W-1:0]   value_reg;

    logic [PTR_W-1:0]              head_reg [NUM_STACKS];
    logic [PTR_W-1:0]              head_next;
    logic                          head_we;

    logic                          done_reg;
    logic [spms_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [spms_pkg::DATA_W-1:0]   data_reg, data_next;

    logic                          accept;
    logic                          exec;
    logic [SIDX_W-1:0]             sid_wide;
    logic [SID_W-1:0]              sid_in;
    logic                          sid_in_ok;
    logic [PTR_W-1:0]              head_in;
    logic [PTR_W-1:0]              head_cur;
    logic                          head_ok;

    logic                          node_we;
    logic [NODE_W-1:0]             node_rdata;
    logic [PTR_W-1:0]              node_link;
    logic [PTR_W-1:0]              link_in;

    spms_pkg::fl_ctrl_t            fl_ctrl;
    spms_pkg::fl_stat_t            fl_stat;
    logic [PTR_W-1:0]              fl_alloc;
    logic [PTR_W-1:0]              fl_count;

    assign exec   = state_reg == spms_pkg::S_EXEC;
    assign busy   = exec;
    assign accept = start && !busy;

    assign sid_wide  = SIDX_W'(stack_id);
    assign sid_in    = sid_wide[SID_W-1:0];
    assign sid_in_ok = sid_wide < SIDX_W'(NUM_STACKS);

    // Head selection by compare, so an out-of-range id simply selects null.
    always_comb
    begin
        head_in  = NODE_NULL;
        head_cur = NODE_NULL;
        for (int i = 0; i < NUM_STACKS; i++)
        begin
            if (sid_in == SID_W'(i))
            begin
                head_in = head_reg[i];
            end
            if (sid_reg == SID_W'(i))
            begin
                head_cur = head_reg[i];
            end
        end
    end

    assign head_ok   = head_cur < NODE_NULL;
    assign node_link = node_rdata[PTR_W-1:0];
    assign link_in   = head_ok ? head_cur : NODE_NULL;

    always_comb
    begin
        state_next   = state_reg;
        case (state_reg)
            spms_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = spms_pkg::S_EXEC;
                end
            end
            spms_pkg::S_EXEC:
            begin
                state_next = spms_pkg::S_IDLE;
            end
            default:
            begin
                state_next = spms_pkg::S_IDLE;
            end
        endcase
    end

    // Execute-cycle decision: status, data and the state updates.
    always_comb
    begin
        status_next  = spms_pkg::STATUS_OK;
        data_next    = '0;
        head_next    = NODE_NULL;
        head_we      = 1'b0;
        node_we      = 1'b0;
        fl_ctrl.take = 1'b0;
        fl_ctrl.give = 1'b0;
        if (exec)
        begin
            case (cmd_reg)
                spms_pkg::CMD_PUSH:
                begin
                    if (!sid_ok_reg)
                    begin
                        status_next = spms_pkg::STATUS_EMPTY;
                    end
                    else if (fl_stat.none_free)
                    begin
                        status_next = spms_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        fl_ctrl.take = 1'b1;
                        node_we      = 1'b1;
                        head_we      = 1'b1;
                        head_next    = fl_alloc;
                    end
                end
                spms_pkg::CMD_POP:
                begin
                    if (!sid_ok_reg || !head_ok)
                    begin
                        status_next = spms_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        fl_ctrl.give = 1'b1;
                        head_we      = 1'b1;
                        head_next    = (node_link < NODE_NULL) ? node_link : NODE_NULL;
                    end
                end
                spms_pkg::CMD_TOP:
                begin
                    if (!sid_ok_reg || !head_ok)
                    begin
                        status_next = spms_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        data_next = node_rdata[NODE_W-1:PTR_W];
                    end
                end
                default:
                begin
                    status_next = spms_pkg::STATUS_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spms_pkg::S_IDLE;
            done_reg  <= 1'b0;
            for (int i = 0; i < NUM_STACKS; i++)
            begin
                head_reg[i] <= NODE_NULL;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= exec;
            if (head_we)
            begin
                head_reg[sid_reg] <= head_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= cmd;
            sid_reg    <= sid_in;
            sid_ok_reg <= sid_in_ok;
            value_reg  <= value;
        end
        if (exec)
        begin
            status_reg <= status_next;
            data_reg   <= data_next;
        end
    end

    assign done   = done_reg;
    assign status = status_reg;
    assign data   = data_reg;

    // Node RAM: value above link. Read at the addressed head in the command cycle.
    spms_ram #(
        .WIDTH (NODE_W),
        .DEPTH (POOL)
    ) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (fl_alloc[ADDR_W-1:0]),
        .wdata ({value_reg, link_in}),
        .re    (accept),
        .raddr (head_in[ADDR_W-1:0]),
        .rdata (node_rdata)
    );

    spms_free_list #(
        .ENTRIES_PER_STACK (ENTRIES_PER_STACK),
        .NUM_STACKS        (NUM_STACKS)
    ) u_free_list (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (fl_ctrl),
        .give_idx  (head_cur),
        .alloc_idx (fl_alloc),
        .stat      (fl_stat),
        .count     (fl_count)
    );

    `SPMS_ASSERT_NEXT(a_accept_to_exec, clk, rst_n, accept, busy)
    `SPMS_ASSERT_NEXT(a_exec_to_done, clk, rst_n, exec, done && !busy)
    `SPMS_ASSERT_SAME(a_count_in_pool, clk, rst_n, 1'b1, fl_count <= NODE_NULL)
    `SPMS_ASSERT_SAME(a_take_has_node, clk, rst_n, fl_ctrl.take, fl_alloc < NODE_NULL)

endmodule

`default_nettype wire

// ===== rtl/spms_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module spms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/spms_free_list.sv =====
// Free list of pool nodes: a stack of node indices in one RAM plus its count.
// Depends on spms_pkg and spms_ram.
`default_nettype none

module spms_free_list #(
    parameter int ENTRIES_PER_STACK = spms_pkg::ENTRIES_PER_STACK_DEF,
    parameter int NUM_STACKS        = spms_pkg::NUM_STACKS_DEF,
    localparam int POOL   = NUM_STACKS * ENTRIES_PER_STACK,
    localparam int PTR_W  = $clog2(POOL + 1),
    localparam int ADDR_W = $clog2(POOL)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire spms_pkg::fl_ctrl_t  ctrl,
    input  wire logic [PTR_W-1:0]    give_idx,
    output logic      [PTR_W-1:0]    alloc_idx,
    output spms_pkg::fl_stat_t       stat,
    output logic      [PTR_W-1:0]    count
);

    localparam logic [PTR_W-1:0] POOL_P = PTR_W'(POOL);

    logic [PTR_W-1:0]  count_reg, count_next;
    // Lowest count ever reached: slots below it still hold their reset index.
    logic [PTR_W-1:0]  low_reg, low_next;
    logic [PTR_W-1:0]  top_pos;
    logic [ADDR_W-1:0] ram_rdata;
    logic              pristine;
    logic              give_ok;

    assign top_pos  = count_reg - PTR_W'(1);
    assign pristine = top_pos < low_reg;
    assign give_ok  = ctrl.give && stat.room;

    // The slot never written holds the index that reset placed there.
    assign alloc_idx = pristine ? (POOL_P - count_reg) : PTR_W'(ram_rdata);

    assign stat.none_free = (count_reg == '0) || (count_reg > POOL_P) || (alloc_idx >= POOL_P);
    assign stat.room      = count_reg < POOL_P;
    assign count          = count_reg;

    always_comb
    begin
        count_next = count_reg;
        low_next   = low_reg;
        if (ctrl.take)
        begin
            count_next = top_pos;
            if (pristine)
            begin
                low_next = top_pos;
            end
        end
        else if (give_ok)
        begin
            count_next = count_reg + PTR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= POOL_P;
            low_reg   <= POOL_P;
        end
        else
        begin
            count_reg <= count_next;
            low_reg   <= low_next;
        end
    end

    // The top slot is read every cycle. The count only moves in the execute
    // cycle, and the idle state always comes between two execute states, so the
    // registered data matches the current count whenever it is used.
    spms_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (POOL)
    ) u_free_ram (
        .clk   (clk),
        .we    (give_ok),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (give_idx[ADDR_W-1:0]),
        .re    (1'b1),
        .raddr (top_pos[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

// ===== bench/shared_pool_multi_stack_checker.sv =====
// Checker for the shared-pool multi-stack: watches command and result beats,
// predicts each result from its own copy of the stacks and free list, compares.
// Depends on spms_pkg for widths and command and status codes.
`default_nettype none

module shared_pool_multi_stack_checker #(
    parameter int ENTRIES_PER_STACK = spms_pkg::ENTRIES_PER_STACK_DEF,
    parameter int NUM_STACKS        = spms_pkg::NUM_STACKS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic                                busy,
    input  wire logic [spms_pkg::CMD_W-1:0]          cmd,
    input  wire logic [1:0]                          stack_id,
    input  wire logic signed [spms_pkg::DATA_W-1:0]  value,
    input  wire logic                                done,
    input  wire logic [spms_pkg::STATUS_W-1:0]       status,
    input  wire logic signed [spms_pkg::DATA_W-1:0]  data,
    output int                                       fail_count,
    output int                                       pending,
    output int                                       replies_checked,
    output int                                       full_replies,
    output int                                       empty_replies
);
    import spms_pkg::*;

    localparam int POOL_NODES = NUM_STACKS * ENTRIES_PER_STACK;
    localparam logic [12:0] NODE_NONE = 13'(POOL_NODES);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   data;
    } stack_reply_t;

    logic [12:0]       head_ptr  [NUM_STACKS];
    logic [11:0]       free_node [POOL_NODES];
    logic [11:0]       free_total;
    logic [DATA_W-1:0] node_val  [POOL_NODES];
    logic [12:0]       node_next [POOL_NODES];

    stack_reply_t reply_q[$];
    int           mismatches;
    int           checked;
    int           fulls;
    int           empties;

    function automatic stack_reply_t apply_command(input logic [CMD_W-1:0] c,
                                                   input logic [1:0] sid,
                                                   input logic [DATA_W-1:0] v);
        stack_reply_t r;
        logic [12:0]  hd;
        logic [11:0]  node;
        r.status = STATUS_OK;
        r.data   = '0;
        if (c != CMD_PUSH && c != CMD_POP && c != CMD_TOP)
            return r;
        if (int'(sid) >= NUM_STACKS)
        begin
            r.status = STATUS_EMPTY;
            return r;
        end
        hd = head_ptr[sid];
        if (c == CMD_PUSH)
        begin
            if (free_total == 12'd0)
            begin
                r.status = STATUS_FULL;
                return r;
            end
            node = free_node[free_total - 12'd1];
            free_total = free_total - 12'd1;
            node_val[node]  = v;
            node_next[node] = hd;
            head_ptr[sid]   = 13'(node);
            return r;
        end
        if (hd == NODE_NONE)
        begin
            r.status = STATUS_EMPTY;
            return r;
        end
        if (c == CMD_TOP)
        begin
            r.data = node_val[hd[11:0]];
            return r;
        end
        // Pop hands the head node back to the free list and follows its link.
        free_node[free_total] = hd[11:0];
        free_total = free_total + 12'd1;
        head_ptr[sid] = node_next[hd[11:0]];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        stack_reply_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STACKS; i++)
                head_ptr[i] = NODE_NONE;
            // Index 0 sits on top of the free list after reset.
            for (int i = 0; i < POOL_NODES; i++)
                free_node[i] = 12'(POOL_NODES - 1 - i);
            free_total = 12'(POOL_NODES);
            reply_q.delete();
        end
        else
        begin
            if (done)
            begin
                if (reply_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: status %0d data %h", status, data);
                end
                else
                begin
                    want = reply_q.pop_front();
                    checked++;
                    if (status == STATUS_FULL)
                        fulls++;
                    if (status == STATUS_EMPTY)
                        empties++;
                    if (status !== want.status || data !== want.data)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: expected status %0d data %h, got status %0d data %h",
                                     checked, want.status, want.data, status, data);
                    end
                end
            end
            if (start && !busy)
                reply_q.push_back(apply_command(cmd, stack_id, value));
        end
        fail_count      <= mismatches;
        pending         <= reply_q.size();
        replies_checked <= checked;
        full_replies    <= fulls;
        empty_replies   <= empties;
    end

endmodule

`default_nettype wire

// ===== bench/shared_pool_multi_stack_test.sv =====
// Top of the shared-pool multi-stack testbench: clock, reset, command stimulus
// and the verdict. Depends on spms_pkg, the block and shared_pool_multi_stack_checker.
`default_nettype none

module shared_pool_multi_stack_test;
    import spms_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    logic                      clk;
    logic                      rst_n    = 1'b0;
    logic                      start    = 1'b0;
    logic [CMD_W-1:0]          cmd      = CMD_PUSH;
    logic [1:0]                stack_id = '0;
    logic signed [DATA_W-1:0]  value    = '0;
    logic                      busy;
    logic                      done;
    logic [STATUS_W-1:0]       status;
    logic signed [DATA_W-1:0]  data;

    int fail_count;
    int pending;
    int replies_checked;
    int full_replies;
    int empty_replies;
    int cycle_count = 0;
    int idle_pct    = 0;
    int beats_sent  = 0;

    shared_pool_multi_stack dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .stack_id (stack_id),
        .value    (value),
        .done     (done),
        .status   (status),
        .data     (data)
    );

    shared_pool_multi_stack_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .cmd             (cmd),
        .stack_id        (stack_id),
        .value           (value),
        .done            (done),
        .status          (status),
        .data            (data),
        .fail_count      (fail_count),
        .pending         (pending),
        .replies_checked (replies_checked),
        .full_replies    (full_replies),
        .empty_replies   (empty_replies)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("shared_pool_multi_stack verification failed");
            $finish;
        end
    end

    // Present one command beat and hold it until the block takes it.
    task automatic issue(input logic [CMD_W-1:0] c, input logic [1:0] sid,
                         input logic [DATA_W-1:0] v);
        start    <= 1'b1;
        cmd      <= c;
        stack_id <= sid;
        value    <= v;
        do
            @(posedge clk);
        while (busy);
        beats_sent++;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Stop sending and wait until every outstanding result has come back.
    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_value;
        case ($urandom_range(19))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly well-formed push, pop and top traffic, with a little noise on
    // the unused command code and the stack id beyond the last stack.
    task automatic random_command(input int push_pct);
        int          roll;
        logic [CMD_W-1:0] c;
        logic [1:0]  sid;
        roll = $urandom_range(99);
        sid  = 2'($urandom_range(NUM_STACKS_DEF - 1));
        if (roll < push_pct)
            c = CMD_PUSH;
        else if (roll < push_pct + (95 - push_pct) * 6 / 10)
            c = CMD_POP;
        else if (roll < 95)
            c = CMD_TOP;
        else
        begin
            c   = 2'($urandom_range(3));
            sid = 2'($urandom_range(3));
        end
        issue(c, sid, pick_value());
    endtask

    task automatic random_run(input int beats);
        int push_pct;
        push_pct = 45;
        for (int i = 0; i < beats; i++)
        begin
            if (i % 40 == 0)
                push_pct = $urandom_range(25, 65);
            random_command(push_pct);
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty stacks, extreme values, every command, bad ids.
        issue(CMD_TOP,  2'd0, '0);
        issue(CMD_POP,  2'd1, '0);
        issue(CMD_PUSH, 2'd0, 32'h7fff_ffff);
        issue(CMD_PUSH, 2'd1, 32'h8000_0000);
        issue(CMD_PUSH, 2'd2, 32'h0000_0000);
        issue(CMD_PUSH, 2'd2, 32'hffff_ffff);
        issue(CMD_TOP,  2'd0, '0);
        issue(CMD_TOP,  2'd1, '0);
        issue(CMD_TOP,  2'd2, '0);
        issue(CMD_PUSH, 2'd3, 32'h1234_5678);
        issue(CMD_POP,  2'd3, '0);
        issue(CMD_TOP,  2'd3, '0);
        issue(2'd3,     2'd0, 32'hdead_beef);
        issue(2'd3,     2'd3, 32'hffff_ffff);
        issue(CMD_POP,  2'd2, '0);
        issue(CMD_TOP,  2'd2, '0);
        issue(CMD_POP,  2'd2, '0);
        issue(CMD_POP,  2'd2, '0);
        issue(CMD_TOP,  2'd2, '0);
        issue(CMD_POP,  2'd0, '0);
        issue(CMD_POP,  2'd1, '0);
        issue(CMD_TOP,  2'd1, '0);

        idle_pct = 38;
        random_run(310);
        drain();
        idle_pct = 63;
        random_run(310);
        idle_pct = 0;
        random_run(310);

        drain();
        repeat (6) @(posedge clk);
        $display("Sent %0d command beats: a directed opening, then three gap mixes;",
                 beats_sent);
        $display("checked %0d results, %0d of them pool full and %0d stack empty.",
                 replies_checked, full_replies, empty_replies);
        if (fail_count == 0 && pending == 0)
            $display("shared_pool_multi_stack verification clean");
        else
            $display("shared_pool_multi_stack verification failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/spms_pkg.sv
rtl/spms_ram.sv
rtl/spms_free_list.sv
rtl/shared_pool_multi_stack.sv
bench/shared_pool_multi_stack_checker.sv
bench/shared_pool_multi_stack_test.sv
